>>> design/ring_buffer_deque_core_defines.svh
// Assertion macros shared by the deque core modules.
`ifndef RING_BUFFER_DEQUE_CORE_DEFINES_SVH
`define RING_BUFFER_DEQUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque core check failed");

// next-cycle implication, disabled while in reset
`define RBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque core check failed");

`endif

>>> design/rbd_pkg.sv
package rbd_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] DATA_EMPTY_POP = {DATA_W{1'b1}};

    typedef logic [1:0] rbd_op_t;
    localparam rbd_op_t OP_WRITE  = 2'd0;
    localparam rbd_op_t OP_READ   = 2'd1;
    localparam rbd_op_t OP_FULL   = 2'd2;
    localparam rbd_op_t OP_EMPTY  = 2'd3;

    typedef struct packed {
        logic    load_in;
        logic    exec;
        rbd_op_t op;
        logic    load_out;
    } rbd_cmd_t;

    typedef struct packed {
        logic is_push;
        logic empty;
        logic full;
    } rbd_stat_t;

endpackage

>>> design/ring_buffer_deque_core.sv
// Channel  Dir  tdata (low bit up)   tuser (low bit up)
// s_       in   value[31:0]          kind[1:0]
// m_       out  data[31:0]           status[1:0], now_empty[2]
//
// A word is accepted only while idle, then passes three steps: capture, store access
// (one port, read data registered), result load into the output register.
// The result is offered once the RESP state loads it, as s_tready rises again.
// A new word is accepted while the previous result waits in the output register.
// A stalled m_ side holds the result stage until the output register frees.
// aresetn (synchronous) clears the indices and count; store contents are not reset.

module ring_buffer_deque_core
    import rbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // data[31:0]
    output logic [2:0]  m_tuser   // status[1:0], now_empty[2]
);

    rbd_cmd_t            cmd;
    rbd_stat_t           stat;
    logic [DATA_W-1:0]   out_data;
    logic [STATUS_W-1:0] out_status;
    logic                out_empty;

    rbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_value   (s_tdata),
        .out_data   (out_data),
        .out_status (out_status),
        .out_empty  (out_empty)
    );

    assign m_tdata = out_data;
    assign m_tuser = {out_empty, out_status};

endmodule

>>> design/rbd_datapath.sv
`include "ring_buffer_deque_core_defines.svh"

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbd_cmd_t            cmd,
    output rbd_stat_t           stat,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [DATA_W-1:0]   in_value,
    output logic [DATA_W-1:0]   out_data,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [DATA_W-1:0]   mem [DEPTH];

    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [AW-1:0]       front_reg, front_next;
    logic [AW-1:0]       back_reg, back_next;
    logic [CW-1:0]       count_reg, count_next;
    rbd_op_t             op_reg;
    logic [DATA_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                empty_reg;

    logic [AW-1:0]       front_prev, front_inc, back_prev, back_inc;
    logic [AW-1:0]       mem_addr;
    logic                mem_we, mem_re;

    assign front_prev = (front_reg == '0) ? IDX_LAST : front_reg - AW'(1);
    assign front_inc  = (front_reg == IDX_LAST) ? '0 : front_reg + AW'(1);
    assign back_prev  = (back_reg == '0) ? IDX_LAST : back_reg - AW'(1);
    assign back_inc   = (back_reg == IDX_LAST) ? '0 : back_reg + AW'(1);

    assign stat.is_push = (kind_reg == KIND_PUSH_FRONT) || (kind_reg == KIND_PUSH_BACK);
    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (count_reg >= CNT_FULL);

    assign mem_we = cmd.exec && (cmd.op == OP_WRITE);
    assign mem_re = cmd.exec && (cmd.op == OP_READ);

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        mem_addr   = front_reg;
        case (kind_reg)
            KIND_PUSH_FRONT: begin
                mem_addr = front_prev;
                if (mem_we) begin
                    front_next = front_prev;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_PUSH_BACK: begin
                mem_addr = back_reg;
                if (mem_we) begin
                    back_next  = back_inc;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP_FRONT: begin
                mem_addr = front_reg;
                if (mem_re) begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_POP_BACK: begin
                mem_addr = back_prev;
                if (mem_re) begin
                    back_next  = back_prev;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                mem_addr = front_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= value_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
        end
        if (cmd.exec) begin
            op_reg <= cmd.op;
        end
        if (cmd.load_out) begin
            empty_reg <= (count_reg == '0);
            case (op_reg)
                OP_WRITE: begin
                    data_reg   <= '0;
                    status_reg <= STATUS_OK;
                end
                OP_READ: begin
                    data_reg   <= rd_data_reg;
                    status_reg <= STATUS_OK;
                end
                OP_FULL: begin
                    data_reg   <= '0;
                    status_reg <= STATUS_FULL;
                end
                OP_EMPTY: begin
                    data_reg   <= DATA_EMPTY_POP;
                    status_reg <= STATUS_EMPTY;
                end
                default: begin
                    data_reg   <= '0;
                    status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    assign out_data   = data_reg;
    assign out_status = status_reg;
    assign out_empty  = empty_reg;

    `RBD_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)
    `RBD_ASSERT_NOW(a_ends_meet, aclk, aresetn, (count_reg == '0) || (count_reg == CNT_FULL), front_reg == back_reg)
    `RBD_ASSERT_NEXT(a_write_grows, aclk, aresetn, mem_we, count_reg == $past(count_reg) + CW'(1))

endmodule

>>> design/rbd_ctrl.sv
`include "ring_buffer_deque_core_defines.svh"

module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  rbd_stat_t stat,
    output rbd_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        if (stat.is_push) begin
            cmd.op = stat.full ? OP_FULL : OP_WRITE;
        end else begin
            cmd.op = stat.empty ? OP_EMPTY : OP_READ;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RBD_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out, !out_valid_reg || m_tready)
    `RBD_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_tvalid && s_tready, cmd.exec)
    `RBD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule
